@@ rtl/core/rsre_pkg.sv @@
// shared constants, state encoding and inter-module structs for the ring extraction core
package rsre_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int IDX_W       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
   localparam int VALUE_W     = 7;
   localparam int STEP_W      = 6;
   localparam int TOTAL_W     = 12;
   localparam int STEP_MAX    = 63;
   localparam int TOTAL_MAX   = 4095;
   localparam int RESET_ITEMS = (64 > MAX_ITEMS) ? MAX_ITEMS : 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_SCAN,
      ST_DECIDE,
      ST_FRONT,
      ST_EMIT
   } state_type;

   // control from the sequencer to the presence map
   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] load_count;
      logic             clear;
      logic [IDX_W-1:0] idx;
   } ring_ctl_type;

   typedef struct packed {
      logic [STEP_W-1:0]  step_count;
      logic               went_right;
      logic [TOTAL_W-1:0] total_steps;
      logic               not_present;
   } result_type;

endpackage

@@ rtl/core/ring_shortest_rotation_extract_core.sv @@
// top level of the ring extraction core: stream ports, size register and result register
// the sequencer walks k ring positions from the front to the value and then d more
// on to the next present value (k + d <= MAX_ITEMS); an absent value skips both walks,
// and the walk to the next present value is skipped when the last value is taken
// one request at a time: a new request transfers only once the sequencer is idle again
// reset: synchronous, loads 1..64 (clamped to MAX_ITEMS), clears the total, size reg 64
module ring_shortest_rotation_extract_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] wanted_value
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] step_count, [6] went_right,
                                    // [18:7] total_steps, [23:19] zero
   output logic [0:0]  rsp_tuser,   // [0] not_present
   // size register write port
   input  logic        csr_wen,
   input  logic [6:0]  csr_wdata    // ring_items
);
   import rsre_pkg::*;

   logic [CNT_W-1:0] ring_items_ff, ring_items_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff, rsp_res_in;

   logic             start;
   logic             seq_idle;
   logic             seq_done;
   logic             out_free;
   result_type       seq_result;

   // size register, clamped to the ring capacity on write
   always_comb begin
      ring_items_in = ring_items_ff;
      if (csr_wen) begin
         ring_items_in = (32'(csr_wdata) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS)
                                                       : CNT_W'(csr_wdata);
      end
   end

   // request transfer only while the sequencer is idle
   assign req_tready = seq_idle;
   assign start      = req_tvalid && req_tready;

   // result register frees when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   rsre_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .restart      (req_tdata[0]),
      .wanted_value (req_tdata[7:1]),
      .ring_items   (ring_items_ff),
      .out_free     (out_free),
      .idle         (seq_idle),
      .done         (seq_done),
      .result       (seq_result)
   );

   // result holding register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = seq_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_items_ff <= CNT_W'(RESET_ITEMS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         ring_items_ff <= ring_items_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_res_ff.total_steps, rsp_res_ff.went_right,
                        rsp_res_ff.step_count};
   assign rsp_tuser  = rsp_res_ff.not_present;

endmodule

@@ rtl/core/rsre_ring.sv @@
// presence map of the ring: one bit per value, reload, single-bit clear and one read port
module rsre_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  rsre_pkg::ring_ctl_type ctl,
   output logic                  rd_bit
);
   import rsre_pkg::*;

   logic [MAX_ITEMS-1:0] map_ff;
   logic [MAX_ITEMS-1:0] map_in;
   logic [MAX_ITEMS-1:0] load_mask;
   logic [MAX_ITEMS-1:0] reset_mask;

   // positions below the fill count (values 1 to the fill count) are present after a reload
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         load_mask[i]  = (CNT_W'(i) < ctl.load_count);
         reset_mask[i] = (i < RESET_ITEMS);
      end
   end

   always_comb begin
      map_in = map_ff;
      if (ctl.load) begin
         map_in = load_mask;
      end else if (ctl.clear) begin
         map_in[ctl.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= reset_mask;
      end else begin
         map_ff <= map_in;
      end
   end

   assign rd_bit = map_ff[ctl.idx];

endmodule

@@ rtl/core/rsre_seq.sv @@
// sequencer: walks the ring one position a cycle to count, decide and find the new front
module rsre_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     restart,
   input  logic [rsre_pkg::VALUE_W-1:0] wanted_value,
   input  logic [rsre_pkg::CNT_W-1:0]   ring_items,
   input  logic                     out_free,
   output logic                     idle,
   output logic                     done,
   output rsre_pkg::result_type     result
);
   import rsre_pkg::*;

   state_type          state_ff, state_in;
   logic               restart_ff, restart_in;
   logic               in_range_ff, in_range_in;
   logic [IDX_W-1:0]   target_ff, target_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   p_ff, p_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [CNT_W-1:0]   remaining_ff, remaining_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   result_type         res_ff, res_in;

   ring_ctl_type       ring_ctl;
   logic               rd_bit;
   logic               found;
   logic               go_left;
   logic [CNT_W-1:0]   steps;
   logic [TOTAL_W:0]   sum;
   logic [IDX_W-1:0]   pos_next;

   rsre_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ring_ctl),
      .rd_bit (rd_bit)
   );

   // ring position after pos, with wrap
   assign pos_next = (32'(pos_ff) == MAX_ITEMS - 1) ? '0 : pos_ff + IDX_W'(1);

   assign found   = in_range_ff && (remaining_ff != '0) && rd_bit;
   // left when 2p + 1 <= remaining
   assign go_left = ({1'b0, p_ff, 1'b1} <= {1'b0, 1'b0, remaining_ff});
   assign steps   = go_left ? p_ff : (remaining_ff - p_ff);
   assign sum     = (TOTAL_W + 1)'(total_ff) + (TOTAL_W + 1)'(steps);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = found ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (pos_ff == target_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (remaining_ff == CNT_W'(1)) ? ST_EMIT : ST_FRONT;
         end
         ST_FRONT: begin
            if (rd_bit) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      restart_in      = restart_ff;
      in_range_in     = in_range_ff;
      target_in       = target_ff;
      pos_in          = pos_ff;
      p_in            = p_ff;
      front_in        = front_ff;
      remaining_in    = remaining_ff;
      total_in        = total_ff;
      res_in          = res_ff;
      ring_ctl.load       = 1'b0;
      ring_ctl.load_count = ring_items;
      ring_ctl.clear      = 1'b0;
      ring_ctl.idx        = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               restart_in  = restart;
               in_range_in = (wanted_value != '0) && (32'(wanted_value) <= MAX_ITEMS);
               target_in   = IDX_W'(wanted_value - VALUE_W'(1));
            end
         end
         ST_LOAD: begin
            if (restart_ff) begin
               ring_ctl.load = 1'b1;
               front_in      = '0;
               remaining_in  = ring_items;
               total_in      = '0;
            end
         end
         ST_CHECK: begin
            ring_ctl.idx = target_ff;
            pos_in       = front_ff;
            p_in         = '0;
            if (!found) begin
               res_in.step_count  = '0;
               res_in.went_right  = 1'b0;
               res_in.total_steps = total_ff;
               res_in.not_present = 1'b1;
            end
         end
         ST_SCAN: begin
            if (pos_ff != target_ff) begin
               if (rd_bit) p_in = p_ff + CNT_W'(1);
               pos_in = pos_next;
            end
         end
         ST_DECIDE: begin
            total_in = (32'(sum) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : sum[TOTAL_W-1:0];
            res_in.step_count  = (32'(steps) > STEP_MAX) ? STEP_W'(STEP_MAX) : STEP_W'(steps);
            res_in.went_right  = !go_left;
            res_in.total_steps = total_in;
            res_in.not_present = 1'b0;
            ring_ctl.clear     = 1'b1;
            remaining_in       = remaining_ff - CNT_W'(1);
            pos_in             = pos_next;
         end
         ST_FRONT: begin
            if (rd_bit) begin
               front_in = pos_ff;
            end else begin
               pos_in = pos_next;
            end
         end
         ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         remaining_ff <= CNT_W'(RESET_ITEMS);
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         remaining_ff <= remaining_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff  <= restart_in;
      in_range_ff <= in_range_in;
      target_ff   <= target_in;
      pos_ff      <= pos_in;
      p_ff        <= p_in;
      res_ff      <= res_in;
   end

   assign idle   = (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_EMIT) && out_free;
   assign result = res_ff;

endmodule
